// ===== src/psdh_pkg.sv =====
`default_nettype none
package psdh_pkg;

	localparam int NUM_BINS    = 256;
	localparam int NUM_STATES  = 4;
	localparam int COUNT_WIDTH = 20;
	localparam int DIST_WIDTH  = 16;

	localparam int STORE_DEPTH = NUM_STATES * NUM_BINS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int BIN_W       = $clog2(NUM_BINS);

	// fixed field and register widths
	localparam int OP_W       = 2;
	localparam int LABEL_W    = 2;
	localparam int SEL_W      = 8;
	localparam int INDEX_W    = 8;
	localparam int RANGE_W    = 16;
	localparam int SIU_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// divider width covers both the distance and the range registers
	localparam int DIV_W = (DIST_WIDTH > RANGE_W) ? DIST_WIDTH : RANGE_W;

	localparam logic [OP_W-1:0] OP_RECORD     = 2'd0;
	localparam logic [OP_W-1:0] OP_READ       = 2'd1;
	localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STATES_IN_USE = 2'd3;

	localparam logic [RANGE_W-1:0] RANGE_LOW_RST     = 16'd0;
	localparam logic [RANGE_W-1:0] RANGE_HIGH_RST    = 16'd65535;
	localparam logic [RANGE_W-1:0] BIN_WIDTH_RST     = 16'd256;
	localparam logic [SIU_W-1:0]   STATES_IN_USE_RST = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic load;       // latch the input item
		logic clr_wr;     // clearing pass write
		logic div_start;  // launch bin division
		logic mem_rd;     // read the addressed counter
		logic update;     // write back and emit result from the counter
		logic emit_zero;  // emit a result with count 0
	} psdh_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic is_record;
		logic rec_ok;
		logic rd_ok;
		logic div_done;
		logic bin_ok;
	} psdh_stat_t;

	function automatic logic [ADDR_W-1:0] mem_addr(input logic [LABEL_W-1:0] lbl,
		input logic [BIN_W-1:0] bin);
		mem_addr = ADDR_W'(int'(lbl) * NUM_BINS + int'(bin));
	endfunction

endpackage
`default_nettype wire

// ===== src/psdh_div.sv =====
`default_nettype none
module psdh_div import psdh_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic      [DIV_W-1:0] quotient,
	output logic                  done
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvs_q;

	logic [DIV_W:0]   rem_sh;
	logic [DIV_W:0]   diff;
	logic             ge;
	logic [DIV_W-1:0] rem_next;

	// restoring division, one quotient bit per cycle
	always_comb begin
		rem_sh   = {rem_q, quo_q[DIV_W-1]};
		diff     = rem_sh - {1'b0, dvs_q};
		ge       = rem_sh >= {1'b0, dvs_q};
		rem_next = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

`ifndef SYNTH
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q))
		else $error("divider done without a running division");
	a_no_start_while_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !start)
		else $error("divider restarted mid-division");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done longer than one cycle");
`endif

endmodule
`default_nettype wire

// ===== src/psdh_datapath.sv =====
`default_nettype none
module psdh_datapath import psdh_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire psdh_cmd_t             cmd,
	output psdh_stat_t                 stat,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [OP_W-1:0]       op,
	input  wire logic [DIST_WIDTH-1:0] distance,
	input  wire logic [LABEL_W-1:0]    state_label,
	input  wire logic [SEL_W-1:0]      bin_select,
	output logic                       done,
	output logic                       accepted,
	output logic [INDEX_W-1:0]         bin_index,
	output logic [COUNT_WIDTH-1:0]     count
);

	// configuration
	logic [RANGE_W-1:0] range_low_q;
	logic [RANGE_W-1:0] range_high_q;
	logic [RANGE_W-1:0] bin_width_q;
	logic [SIU_W-1:0]   siu_q;

	// latched item
	logic [OP_W-1:0]       op_q;
	logic [DIST_WIDTH-1:0] dist_q;
	logic [LABEL_W-1:0]    label_q;
	logic [SEL_W-1:0]      sel_q;

	// counter store
	logic [COUNT_WIDTH-1:0] mem_q [STORE_DEPTH];
	logic [COUNT_WIDTH-1:0] rd_data_q;
	logic [ADDR_W-1:0]      clr_q;

	// result register
	logic                   done_q;
	logic                   accepted_q;
	logic [INDEX_W-1:0]     bin_index_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic [DIV_W-1:0]       quo;
	logic                   div_done;
	logic [DIV_W-1:0]       dividend;
	logic                   is_record;
	logic                   rec_ok;
	logic                   rd_ok;
	logic                   bin_ok;
	logic [BIN_W-1:0]       bin;
	logic [ADDR_W-1:0]      acc_addr;
	logic [COUNT_WIDTH-1:0] sat_cnt;
	logic                   wr_en;
	logic [ADDR_W-1:0]      wr_addr;
	logic [COUNT_WIDTH-1:0] wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
			bin_width_q  <= BIN_WIDTH_RST;
			siu_q        <= STATES_IN_USE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_LOW:     range_low_q  <= cfg_data[RANGE_W-1:0];
				REG_RANGE_HIGH:    range_high_q <= cfg_data[RANGE_W-1:0];
				REG_BIN_WIDTH:     bin_width_q  <= cfg_data[RANGE_W-1:0];
				REG_STATES_IN_USE: siu_q        <= cfg_data[SIU_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			dist_q  <= distance;
			label_q <= state_label;
			sel_q   <= bin_select;
		end
	end

	always_comb begin
		is_record = (op_q == OP_RECORD);
		// open interval on both limits, label in use, nonzero width
		rec_ok = (bin_width_q != '0)
			&& (32'(dist_q) > 32'(range_low_q))
			&& (32'(dist_q) < 32'(range_high_q))
			&& ({1'b0, label_q} < siu_q)
			&& (32'(label_q) < 32'(NUM_STATES));
		rd_ok    = (32'(sel_q) < 32'(NUM_BINS)) && (32'(label_q) < 32'(NUM_STATES));
		// right-closed bins: (d - low - 1) / width
		dividend = DIV_W'(dist_q) - DIV_W'(range_low_q) - DIV_W'(1);
		bin_ok   = 32'(quo) < 32'(NUM_BINS);
		bin      = is_record ? quo[BIN_W-1:0] : BIN_W'(sel_q);
		acc_addr = mem_addr(label_q, bin);
		sat_cnt  = (rd_data_q == '1) ? rd_data_q : rd_data_q + 1'b1;
	end

	psdh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (DIV_W'(bin_width_q)),
		.quotient (quo),
		.done     (div_done)
	);

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		wr_en   = cmd.clr_wr || (cmd.update && (is_record || op_q == OP_READ_CLEAR));
		wr_addr = cmd.clr_wr ? clr_q : acc_addr;
		wr_data = (cmd.clr_wr || !is_record) ? '0 : sat_cnt;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.mem_rd) begin
			rd_data_q <= mem_q[acc_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update || cmd.emit_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			accepted_q  <= is_record;
			bin_index_q <= is_record ? INDEX_W'(quo) : INDEX_W'(sel_q);
			count_q     <= is_record ? sat_cnt : rd_data_q;
		end else if (cmd.emit_zero) begin
			accepted_q  <= 1'b0;
			bin_index_q <= is_record ? '0 : INDEX_W'(sel_q);
			count_q     <= '0;
		end
	end

	always_comb begin
		stat.clr_last  = (clr_q == ADDR_W'(STORE_DEPTH - 1));
		stat.is_record = is_record;
		stat.rec_ok    = rec_ok;
		stat.rd_ok     = rd_ok;
		stat.div_done  = div_done;
		stat.bin_ok    = bin_ok;
	end

	assign done      = done_q;
	assign accepted  = accepted_q;
	assign bin_index = bin_index_q;
	assign count     = count_q;

endmodule
`default_nettype wire

// ===== src/psdh_ctrl.sv =====
`default_nettype none
module psdh_ctrl import psdh_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire psdh_stat_t stat,
	output psdh_cmd_t       cmd,
	output logic            busy
);

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_DECODE = 6'b000100,
		S_DIV    = 6'b001000,
		S_FETCH  = 6'b010000,
		S_UPDATE = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.is_record) begin
					if (stat.rec_ok) begin
						cmd.div_start = 1'b1;
						state_nx      = S_DIV;
					end else begin
						cmd.emit_zero = 1'b1;
						state_nx      = S_IDLE;
					end
				end else if (stat.rd_ok) begin
					state_nx = S_FETCH;
				end else begin
					cmd.emit_zero = 1'b1;
					state_nx      = S_IDLE;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					if (stat.bin_ok) begin
						state_nx = S_FETCH;
					end else begin
						cmd.emit_zero = 1'b1;
						state_nx      = S_IDLE;
					end
				end
			end
			S_FETCH: begin
				cmd.mem_rd = 1'b1;
				state_nx   = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_nx   = S_IDLE;
			end
			default: state_nx = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != S_IDLE);

`ifndef SYNTH
	a_fetch_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_rd |=> cmd.update)
		else $error("counter read not followed by write-back");
	a_single_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.update && cmd.emit_zero))
		else $error("two results in one cycle");
	a_div_from_decode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> stat.is_record && stat.rec_ok)
		else $error("division launched for a rejected item");
`endif

endmodule
`default_nettype wire

// ===== src/per_state_distance_histogram.sv =====
`default_nettype none
// A record item runs decode, the bit-serial divider that forms the bin, fetch and update; a
// rejected one ends early with a zero result. Read / read-and-clear: decode, fetch, update.
// Throughput: one item at a time; the next item is taken in the cycle its result shows.
// The receiver cannot stall: each result holds for exactly one cycle under done.
// Reset: asynchronous, active low; then a clearing pass zeroes all 1024 counters of the
// memory with busy high. Configuration writes are taken at any time.
module per_state_distance_histogram import psdh_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// item command
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [OP_W-1:0]        op,
	input  wire logic [DIST_WIDTH-1:0]  distance,
	input  wire logic [LABEL_W-1:0]     state_label,
	input  wire logic [SEL_W-1:0]       bin_select,
	// result
	output logic                        done,
	output logic                        accepted,
	output logic [INDEX_W-1:0]          bin_index,
	output logic [COUNT_WIDTH-1:0]      count
);

	psdh_cmd_t  cmd;
	psdh_stat_t stat;

	// Controller: clearing pass, then per item decode -> (divide) -> fetch -> update, or a zero result on rejection.
	psdh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath: config registers, item latch, bin divider, counter memory
	// (one read and one write port, registered read), result register.
	psdh_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.distance    (distance),
		.state_label (state_label),
		.bin_select  (bin_select),
		.done        (done),
		.accepted    (accepted),
		.bin_index   (bin_index),
		.count       (count)
	);

`ifndef SYNTH
	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the block busy");
	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");
	a_accepted_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		accepted && !done |-> !$past(cmd.update))
		else $error("accepted flag set without a result");
	a_counted_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && accepted |-> count != '0)
		else $error("counted sample reports zero count");
`endif

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import psdh_pkg::*;

	// op code 3 has no name in the package; the block treats it as a plain read
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	// hard stop, far above the slowest correct run (~1100 items with random sender gaps,
	// plus the clearing pass of the whole store)
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned MAX_PRINTED = 40;
	localparam int unsigned COUNT_FULL  = (1 << COUNT_WIDTH) - 1;

	// one result item as it shows on the result ports
	typedef struct packed {
		logic                   accepted;
		logic [INDEX_W-1:0]     bin_index;
		logic [COUNT_WIDTH-1:0] count;
	} tally_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   start;
	logic                   busy;
	logic [OP_W-1:0]        op;
	logic [DIST_WIDTH-1:0]  distance;
	logic [LABEL_W-1:0]     state_label;
	logic [SEL_W-1:0]       bin_select;
	logic                   done;
	logic                   accepted;
	logic [INDEX_W-1:0]     bin_index;
	logic [COUNT_WIDTH-1:0] count;

	per_state_distance_histogram dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.distance   (distance),
		.state_label(state_label),
		.bin_select (bin_select),
		.done       (done),
		.accepted   (accepted),
		.bin_index  (bin_index),
		.count      (count)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// Shadow of the block: its own registers and histogram store.
	// ------------------------------------------------------------------
	logic [RANGE_W-1:0]     lim_low;
	logic [RANGE_W-1:0]     lim_high;
	logic [RANGE_W-1:0]     bin_step;
	logic [SIU_W-1:0]       labels_live;
	logic [COUNT_WIDTH-1:0] hist_shadow [STORE_DEPTH];

	// results predicted at acceptance, oldest first
	tally_t expected_tallies [$];

	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned result_seq;

	// sender pacing: bursts of back-to-back items, then a random gap
	bit          gaps_on;
	int unsigned burst_left;

	// last bin a record hit, so reads land on live counters
	logic [BIN_W-1:0]   last_bin;
	logic [LABEL_W-1:0] last_label;

	// Works out the result of one item and applies its effect to the shadow store.
	// Bins are right-closed: bin = (distance - low - 1) / width.
	function automatic tally_t tally_item(input logic [OP_W-1:0] o,
		input logic [DIST_WIDTH-1:0] d, input logic [LABEL_W-1:0] lbl,
		input logic [SEL_W-1:0] sel);
		tally_t      r;
		int unsigned span;
		int unsigned bin;
		int unsigned addr;
		r = '0;
		if (o == OP_RECORD) begin
			if (bin_step != 0 && d > lim_low && d < lim_high
				&& lbl < labels_live && int'(lbl) < NUM_STATES) begin
				span = 32'(d) - 32'(lim_low) - 32'd1;
				bin  = span / 32'(bin_step);
				if (bin < NUM_BINS) begin
					addr = int'(lbl) * NUM_BINS + bin;
					if (hist_shadow[addr] != COUNT_FULL)
						hist_shadow[addr] = hist_shadow[addr] + 1'b1;
					r.accepted  = 1'b1;
					r.bin_index = INDEX_W'(bin);
					r.count     = hist_shadow[addr];
				end
			end
		end else begin
			// read, read-and-clear, and the spare code acting as a read
			r.bin_index = sel;
			if (int'(sel) < NUM_BINS && int'(lbl) < NUM_STATES) begin
				addr    = int'(lbl) * NUM_BINS + int'(sel);
				r.count = hist_shadow[addr];
				if (o == OP_READ_CLEAR)
					hist_shadow[addr] = '0;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("MISMATCH @%0t result #%0d: %s", $time, result_seq, what);
	endtask

	// ------------------------------------------------------------------
	// Result checker: every done cycle is matched against the oldest
	// prediction. The receiver cannot stall, so nothing else to do here.
	// ------------------------------------------------------------------
	tally_t want;

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_tallies.size() == 0) begin
				report_mismatch($sformatf("unexpected result acc=%0b bin=%0d cnt=%0d",
					accepted, bin_index, count));
			end else begin
				want = expected_tallies.pop_front();
				if (accepted !== want.accepted)
					report_mismatch($sformatf("accepted %0b, want %0b",
						accepted, want.accepted));
				if (bin_index !== want.bin_index)
					report_mismatch($sformatf("bin_index %0d, want %0d",
						bin_index, want.bin_index));
				if (count !== want.count)
					report_mismatch($sformatf("count %0d, want %0d", count, want.count));
			end
			result_seq++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Drivers. Inputs move on the falling edge; the handshake is judged
	// on the rising edge.
	// ------------------------------------------------------------------

	// One register write; the shadow copy follows at once since the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_RANGE_LOW:     lim_low     = val;
			REG_RANGE_HIGH:    lim_high    = val;
			REG_BIN_WIDTH:     bin_step    = val;
			REG_STATES_IN_USE: labels_live = val[SIU_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all_regs(input logic [RANGE_W-1:0] lo, input logic [RANGE_W-1:0] hi,
		input logic [RANGE_W-1:0] w, input logic [CFG_DATA_W-1:0] labels);
		write_reg(REG_RANGE_LOW, lo);
		write_reg(REG_RANGE_HIGH, hi);
		write_reg(REG_BIN_WIDTH, w);
		write_reg(REG_STATES_IN_USE, labels);
	endtask

	// Sends one item and records its prediction at the accepting edge.
	// start stays high into the next item unless a gap is due.
	task automatic send_item(input logic [OP_W-1:0] o, input logic [DIST_WIDTH-1:0] d,
		input logic [LABEL_W-1:0] lbl, input logic [SEL_W-1:0] sel);
		tally_t      t;
		int unsigned gap;
		@(negedge clk);
		start       <= 1'b1;
		op          <= o;
		distance    <= d;
		state_label <= lbl;
		bin_select  <= sel;
		do
			@(posedge clk);
		while (busy);
		t = tally_item(o, d, lbl, sel);
		expected_tallies.push_back(t);
		if (t.accepted) begin
			last_bin   = t.bin_index;
			last_label = lbl;
		end
		if (gaps_on) begin
			if (burst_left <= 1) begin
				gap = $urandom_range(1, 30);
				burst_left = $urandom_range(1, 20);
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Lets the block run dry: no item in flight and no result outstanding.
	task automatic drain;
		@(negedge clk);
		start <= 1'b0;
		while (expected_tallies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Default registers (0 / 65535 / 256 / 4): limits, bin edges, every op.
	task automatic test_default_bins;
		gaps_on = 1'b0;
		send_item(OP_RECORD, 16'd0, 2'd0, 8'd0);        // at the lower limit: rejected
		send_item(OP_RECORD, 16'd1, 2'd0, 8'd0);        // first bin
		send_item(OP_RECORD, 16'd256, 2'd0, 8'd0);      // right edge still bin 0
		send_item(OP_RECORD, 16'd257, 2'd0, 8'd0);      // bin 1
		send_item(OP_RECORD, 16'hFFFF, 2'd3, 8'd0);     // at the upper limit: rejected
		send_item(OP_RECORD, 16'hFFFE, 2'd3, 8'd0);     // last bin
		send_item(OP_RECORD, 16'hFFFE, 2'd3, 8'hFF);
		send_item(OP_READ, 16'hFFFF, 2'd0, 8'd0);
		send_item(OP_READ_CLEAR, 16'd0, 2'd0, 8'd0);    // returns the count before clearing
		send_item(OP_READ, 16'd0, 2'd0, 8'd0);          // now zero
		send_item(OP_SPARE, 16'd0, 2'd3, 8'hFF);        // spare code reads
		send_item(OP_READ_CLEAR, 16'd0, 2'd3, 8'hFF);
		send_item(OP_READ, 16'd0, 2'd3, 8'hFF);
		send_item(OP_READ, 16'hA5A5, 2'd2, 8'hAA);      // empty bin in another histogram
		send_item(OP_READ, 16'h5A5A, 2'd1, 8'h55);
		drain();
	endtask

	// Register extremes: label gating, bins past the store, zero width, dead ranges.
	task automatic test_register_edges;
		gaps_on = 1'b0;
		// upper bits beyond the 3-bit register are dropped: 0xFFF9 -> 1 label
		set_all_regs(16'd0, 16'hFFFF, 16'd1, 16'hFFF9);
		send_item(OP_RECORD, 16'd5, 2'd1, 8'd0);        // label not in use
		send_item(OP_RECORD, 16'd256, 2'd0, 8'd0);      // bin 255
		send_item(OP_RECORD, 16'd257, 2'd0, 8'd0);      // bin 256: beyond the store
		drain();
		write_reg(REG_STATES_IN_USE, 16'd0);             // no label counted
		send_item(OP_RECORD, 16'd3, 2'd0, 8'd0);
		drain();
		write_reg(REG_STATES_IN_USE, 16'd7);             // more than exist
		write_reg(REG_BIN_WIDTH, 16'd0);                 // zero width rejects all
		send_item(OP_RECORD, 16'd3, 2'd3, 8'd0);
		drain();
		write_reg(REG_BIN_WIDTH, 16'hFFFF);
		send_item(OP_RECORD, 16'hFFFE, 2'd3, 8'd0);     // single wide bin
		send_item(OP_READ, 16'd0, 2'd3, 8'd0);
		drain();
		write_reg(REG_RANGE_LOW, 16'hFFFF);              // nothing above the lower limit
		send_item(OP_RECORD, 16'hFFFF, 2'd1, 8'd0);
		drain();
		set_all_regs(16'd0, 16'd0, 16'd1, 16'd4);        // nothing below the upper limit
		send_item(OP_RECORD, 16'd0, 2'd2, 8'd0);
		drain();
		set_all_regs(16'd100, 16'd200, 16'd10, 16'd4);
		send_item(OP_RECORD, 16'd100, 2'd2, 8'd0);      // at low
		send_item(OP_RECORD, 16'd101, 2'd2, 8'd0);      // bin 0
		send_item(OP_RECORD, 16'd199, 2'd2, 8'd0);      // bin 9
		send_item(OP_RECORD, 16'd200, 2'd2, 8'd0);      // at high
		drain();
	endtask

	// Random phases: fresh registers each phase, mostly in-range records on
	// live labels, plus noise, reads of the bins just hit and clears.
	task automatic test_random_traffic(input int unsigned phases, input int unsigned per_phase);
		int unsigned lo;
		int unsigned hi;
		int unsigned w;
		int unsigned labels;
		int unsigned pick;
		logic [OP_W-1:0]       o;
		logic [DIST_WIDTH-1:0] d;
		logic [LABEL_W-1:0]    lbl;
		logic [SEL_W-1:0]      sel;
		for (int p = 0; p < phases; p++) begin
			lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2000);
			w  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 64);
			hi = lo + w * $urandom_range(1, 300);
			if (hi > 65535)
				hi = 65535;
			labels = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
			if (p == phases - 1)
				labels = 16'hFFFC | $urandom_range(0, 3);
			set_all_regs(RANGE_W'(lo), RANGE_W'(hi), RANGE_W'(w), CFG_DATA_W'(labels));
			gaps_on    = (p % 3 != 0);
			burst_left = $urandom_range(1, 20);
			for (int unsigned i = 0; i < per_phase; i++) begin
				pick = $urandom_range(0, 99);
				o    = OP_RECORD;
				d    = DIST_WIDTH'($urandom());
				lbl  = LABEL_W'($urandom());
				sel  = SEL_W'($urandom());
				if (pick < 60) begin
					// well-formed record, limits included now and then
					d = DIST_WIDTH'(lo + $urandom_range(0, hi - lo));
					if (labels > 0 && $urandom_range(0, 7) != 0)
						lbl = LABEL_W'($urandom_range(0, (labels > 4 ? 4 : labels) - 1));
				end else if (pick < 90) begin
					o = OP_W'($urandom_range(1, 3));
					if (pick < 80) begin
						sel = last_bin;
						lbl = last_label;
					end
				end
				send_item(o, d, lbl, sel);
			end
			drain();
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		start       = 1'b0;
		op          = OP_RECORD;
		distance    = '0;
		state_label = '0;
		bin_select  = '0;
		lim_low     = RANGE_LOW_RST;
		lim_high    = RANGE_HIGH_RST;
		bin_step    = BIN_WIDTH_RST;
		labels_live = STATES_IN_USE_RST;
		for (int i = 0; i < STORE_DEPTH; i++)
			hist_shadow[i] = '0;
		mismatch_count = 0;
		cycle_count    = 0;
		result_seq     = 0;
		gaps_on        = 1'b0;
		burst_left     = 1;
		last_bin       = '0;
		last_label     = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// clearing pass keeps busy high for the whole store
		repeat (2) @(posedge clk);
		while (busy)
			@(posedge clk);

		test_default_bins();
		test_register_edges();
		test_random_traffic(8, 125);

		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && expected_tallies.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
src/psdh_pkg.sv
src/psdh_div.sv
src/psdh_datapath.sv
src/psdh_ctrl.sv
src/per_state_distance_histogram.sv
sim/testbench.sv
